@@ src/mhps_pkg.sv @@
// Shared types and codes for the media host power sequencer.
package mhps_pkg;

    // Request kinds carried in req_type
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_CMD   = 2'd1;
    localparam logic [1:0] REQ_RETRY = 2'd2;
    localparam logic [1:0] REQ_ARM   = 2'd3;

    // Selected mode
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_OFF  = 2'd2;

    // Supply and button actions
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_ON   = 2'd1;
    localparam logic [1:0] ACT_OFF  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_PORT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_WAIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_WAIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_CODE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_CODE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_CODE  = 3'd7;

    // Configuration reset values
    localparam logic [7:0] OPEN_WAIT_RST   = 8'd10;
    localparam logic [7:0] CLOSE_WAIT_RST  = 8'd60;
    localparam logic [2:0] RETRY_LIMIT_RST = 3'd2;
    localparam logic [7:0] OPEN_CODE_RST   = 8'd1;
    localparam logic [7:0] CLOSE_CODE_RST  = 8'd2;

    typedef struct packed {
        logic       enable;
        logic [7:0] open_wait;
        logic [7:0] close_wait;
        logic [2:0] retry_limit;
        logic [7:0] device_code;
        logic [7:0] open_code;
        logic [7:0] close_code;
    } t_cfg;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] cmd_device;
        logic [7:0] cmd_option;
        logic       sense_off;
        logic       recorder_idle;
        logic       peer_known;
    } t_item;

    typedef struct packed {
        logic       accepted;
        logic [1:0] supply_action;
        logic [1:0] pulse_action;
        logic       status_query;
        logic       address_query;
        logic       forced_shutdown;
        logic       is_on;
        logic       is_off;
    } t_result;

endpackage

@@ src/mhps_cfg.sv @@
// Configuration register file for the media host power sequencer.
module mhps_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr,
    input  logic [mhps_pkg::CFG_IDX_W-1:0]   i_index,
    input  logic [mhps_pkg::CFG_DATA_W-1:0]  i_data,
    output mhps_pkg::t_cfg                   o_cfg
);

    mhps_pkg::t_cfg r_cfg;

    // Load the addressed register; the outlet number drives no logic here, so
    // a write to it is taken and dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable      <= 1'b1;
            r_cfg.open_wait   <= mhps_pkg::OPEN_WAIT_RST;
            r_cfg.close_wait  <= mhps_pkg::CLOSE_WAIT_RST;
            r_cfg.retry_limit <= mhps_pkg::RETRY_LIMIT_RST;
            r_cfg.device_code <= 8'd0;
            r_cfg.open_code   <= mhps_pkg::OPEN_CODE_RST;
            r_cfg.close_code  <= mhps_pkg::CLOSE_CODE_RST;
        end else if (i_wr) begin
            unique case (i_index)
                mhps_pkg::CFG_ENABLE:      r_cfg.enable      <= i_data[0];
                mhps_pkg::CFG_POWER_PORT:  ;
                mhps_pkg::CFG_OPEN_WAIT:   r_cfg.open_wait   <= i_data[7:0];
                mhps_pkg::CFG_CLOSE_WAIT:  r_cfg.close_wait  <= i_data[7:0];
                mhps_pkg::CFG_RETRY_LIMIT: r_cfg.retry_limit <= i_data[2:0];
                mhps_pkg::CFG_DEVICE_CODE: r_cfg.device_code <= i_data[7:0];
                mhps_pkg::CFG_OPEN_CODE:   r_cfg.open_code   <= i_data[7:0];
                mhps_pkg::CFG_CLOSE_CODE:  r_cfg.close_code  <= i_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/mhps_core.sv @@
// Sequencer state and the per-request update logic.
module mhps_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  mhps_pkg::t_cfg    i_cfg,
    input  mhps_pkg::t_item   i_item,
    output mhps_pkg::t_result o_result
);

    logic       r_armed,    n_armed;
    logic       r_on_done,  n_on_done;
    logic       r_off_done, n_off_done;
    logic       r_exit_ok,  n_exit_ok;
    logic [1:0] r_mode,     n_mode;
    logic [7:0] r_tick,     n_tick;
    logic [2:0] r_retry,    n_retry;

    logic       opt_open;
    logic       cmd_ok;
    logic [7:0] wait_lim;
    logic       wait_done;

    mhps_pkg::t_result res;

    // Decode the command match and the active wait limit
    assign opt_open  = (i_item.cmd_option == i_cfg.open_code);
    assign cmd_ok    = (opt_open || i_item.cmd_option == i_cfg.close_code)
                       && (i_item.cmd_device == i_cfg.device_code);
    assign wait_lim  = (r_mode == mhps_pkg::MODE_ON) ? i_cfg.open_wait : i_cfg.close_wait;
    assign wait_done = !(r_tick < wait_lim);

    // Compute next state and the result for the current request
    always_comb begin
        n_armed    = r_armed;
        n_on_done  = r_on_done;
        n_off_done = r_off_done;
        n_exit_ok  = r_exit_ok;
        n_mode     = r_mode;
        n_tick     = r_tick;
        n_retry    = r_retry;
        res        = '0;

        unique case (i_item.req_type)
            mhps_pkg::REQ_CMD: begin
                if (cmd_ok) begin
                    n_mode       = opt_open ? mhps_pkg::MODE_ON : mhps_pkg::MODE_OFF;
                    n_retry      = 3'd0;
                    res.accepted = 1'b1;
                end
            end
            mhps_pkg::REQ_RETRY: begin
                if (r_mode == mhps_pkg::MODE_OFF) begin
                    n_retry = 3'd0;
                end
            end
            mhps_pkg::REQ_ARM: begin
                n_armed    = 1'b1;
                n_on_done  = 1'b0;
                n_off_done = 1'b0;
                n_exit_ok  = 1'b0;
                n_mode     = mhps_pkg::MODE_NONE;
                n_tick     = 8'd0;
                n_retry    = 3'd0;
            end
            mhps_pkg::REQ_TICK: begin
                if (i_cfg.enable && r_armed) begin
                    if (r_mode == mhps_pkg::MODE_ON && !r_on_done) begin
                        // Confirm power-on, or retry the supply and button
                        n_off_done = 1'b0;
                        if (!i_item.sense_off) begin
                            n_on_done = 1'b1;
                            n_exit_ok = 1'b0;
                        end else begin
                            n_tick = wait_done ? 8'd0 : r_tick + 8'd1;
                            if (wait_done) begin
                                res.supply_action = mhps_pkg::ACT_ON;
                                res.pulse_action  = mhps_pkg::ACT_ON;
                            end
                        end
                    end else if (r_mode == mhps_pkg::MODE_OFF && !r_off_done) begin
                        // Drop the supply once off, else press, query or force a shutdown
                        n_on_done = 1'b0;
                        if (i_item.sense_off) begin
                            n_off_done        = 1'b1;
                            n_exit_ok         = 1'b0;
                            res.supply_action = mhps_pkg::ACT_OFF;
                        end else begin
                            if (i_item.recorder_idle) begin
                                n_exit_ok = 1'b1;
                            end
                            n_tick = wait_done ? 8'd0 : r_tick + 8'd1;
                            if (wait_done) begin
                                if (r_exit_ok || i_item.recorder_idle) begin
                                    res.pulse_action = mhps_pkg::ACT_OFF;
                                end else if (r_retry < i_cfg.retry_limit) begin
                                    n_retry           = r_retry + 3'd1;
                                    res.address_query = !i_item.peer_known;
                                    res.status_query  = i_item.peer_known;
                                end else begin
                                    n_retry             = 3'd0;
                                    n_exit_ok           = 1'b1;
                                    res.forced_shutdown = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase

        res.is_on  = n_on_done;
        res.is_off = n_off_done;
    end

    // Hold state until a request steps through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b0;
            r_on_done  <= 1'b0;
            r_off_done <= 1'b0;
            r_exit_ok  <= 1'b0;
            r_mode     <= mhps_pkg::MODE_NONE;
            r_tick     <= 8'd0;
            r_retry    <= 3'd0;
        end else if (i_step) begin
            r_armed    <= n_armed;
            r_on_done  <= n_on_done;
            r_off_done <= n_off_done;
            r_exit_ok  <= n_exit_ok;
            r_mode     <= n_mode;
            r_tick     <= n_tick;
            r_retry    <= n_retry;
        end
    end

    assign o_result = res;

endmodule

@@ src/media_host_power_sequencer.sv @@
// Top level of the media host power sequencer: request and result registers.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+---------------------------------------
//  request  | i_in_valid / o_in_stall      | i_req_type, i_cmd_*, i_sense_off, ...
//  result   | o_out_valid / i_out_stall    | o_accepted, o_supply_action, ... o_is_off
//  config   | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One request per cycle while the result side does not stall; each result passes through the
// request register, which takes the request, and then the result register.
// Reset clears the sequencer state and loads the register defaults; no clearing pass.
// A stalled result holds the result register; the request register then holds too
// and the request side stalls until the result is taken.
module media_host_power_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_req_type,
    input  logic [7:0]                      i_cmd_device,
    input  logic [7:0]                      i_cmd_option,
    input  logic                            i_sense_off,
    input  logic                            i_recorder_idle,
    input  logic                            i_peer_known,

    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_accepted,
    output logic [1:0]                      o_supply_action,
    output logic [1:0]                      o_pulse_action,
    output logic                            o_status_query,
    output logic                            o_address_query,
    output logic                            o_forced_shutdown,
    output logic                            o_is_on,
    output logic                            o_is_off,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mhps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mhps_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    mhps_pkg::t_cfg    cfg;
    mhps_pkg::t_item   r_item;
    mhps_pkg::t_result core_res;
    mhps_pkg::t_result r_res;
    logic              r_item_valid;
    logic              r_res_valid;
    logic              out_free;
    logic              step;
    logic              in_take;

    assign o_cfg_ready = 1'b1;

    mhps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Advance when the result register is empty or being emptied
    assign out_free   = !r_res_valid || !i_out_stall;
    assign step       = r_item_valid && out_free;
    assign o_in_stall = r_item_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_item_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.req_type      <= i_req_type;
            r_item.cmd_device    <= i_cmd_device;
            r_item.cmd_option    <= i_cmd_option;
            r_item.sense_off     <= i_sense_off;
            r_item.recorder_idle <= i_recorder_idle;
            r_item.peer_known    <= i_peer_known;
        end
    end

    mhps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cfg    (cfg),
        .i_item   (r_item),
        .o_result (core_res)
    );

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (out_free) begin
            r_res_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid       = r_res_valid;
    assign o_accepted        = r_res.accepted;
    assign o_supply_action   = r_res.supply_action;
    assign o_pulse_action    = r_res.pulse_action;
    assign o_status_query    = r_res.status_query;
    assign o_address_query   = r_res.address_query;
    assign o_forced_shutdown = r_res.forced_shutdown;
    assign o_is_on           = r_res.is_on;
    assign o_is_off          = r_res.is_off;

endmodule

@@ tb/media_host_power_sequencer_test.sv @@
`timescale 1ns / 1ps
// Testbench for the media host power sequencer: directed and random requests.
module media_host_power_sequencer_test;

    localparam int HALF_PERIOD   = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RETIRE_CYCLES = 8;

    logic                            i_clk           = 1'b0;
    logic                            i_rst_n         = 1'b0;
    logic                            i_in_valid      = 1'b0;
    logic [1:0]                      i_req_type      = mhps_pkg::REQ_TICK;
    logic [7:0]                      i_cmd_device    = 8'd0;
    logic [7:0]                      i_cmd_option    = 8'd0;
    logic                            i_sense_off     = 1'b0;
    logic                            i_recorder_idle = 1'b0;
    logic                            i_peer_known    = 1'b0;
    logic                            i_out_stall     = 1'b0;
    logic                            i_cfg_valid     = 1'b0;
    logic [mhps_pkg::CFG_IDX_W-1:0]  i_cfg_index     = mhps_pkg::CFG_ENABLE;
    logic [mhps_pkg::CFG_DATA_W-1:0] i_cfg_data      = '0;

    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_accepted;
    logic [1:0] o_supply_action;
    logic [1:0] o_pulse_action;
    logic       o_status_query;
    logic       o_address_query;
    logic       o_forced_shutdown;
    logic       o_is_on;
    logic       o_is_off;
    logic       o_cfg_ready;

    media_host_power_sequencer uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_cmd_device      (i_cmd_device),
        .i_cmd_option      (i_cmd_option),
        .i_sense_off       (i_sense_off),
        .i_recorder_idle   (i_recorder_idle),
        .i_peer_known      (i_peer_known),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_accepted        (o_accepted),
        .o_supply_action   (o_supply_action),
        .o_pulse_action    (o_pulse_action),
        .o_status_query    (o_status_query),
        .o_address_query   (o_address_query),
        .o_forced_shutdown (o_forced_shutdown),
        .o_is_on           (o_is_on),
        .o_is_off          (o_is_off),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // Shadow of the register file, starting from the reset values
    mhps_pkg::t_cfg settings = '{enable: 1'b1,
                                 open_wait: mhps_pkg::OPEN_WAIT_RST,
                                 close_wait: mhps_pkg::CLOSE_WAIT_RST,
                                 retry_limit: mhps_pkg::RETRY_LIMIT_RST,
                                 device_code: 8'd0,
                                 open_code: mhps_pkg::OPEN_CODE_RST,
                                 close_code: mhps_pkg::CLOSE_CODE_RST};

    // Predicted sequencer state
    bit         seq_armed    = 1'b0;
    bit         seq_on_done  = 1'b0;
    bit         seq_off_done = 1'b0;
    bit         seq_exit_ok  = 1'b0;
    logic [1:0] seq_mode     = mhps_pkg::MODE_NONE;
    logic [7:0] seq_ticks    = 8'd0;
    logic [2:0] seq_retries  = 3'd0;

    mhps_pkg::t_result expected_results[$];
    int      errors        = 0;
    int      cycle_count   = 0;
    int      hold_left     = 0;
    bit      sender_idle   = 1'b1;
    bit      receiver_idle = 1'b1;

    always #HALF_PERIOD i_clk = ~i_clk;

    // Compare the tick counter against a wait, then advance it; true once the wait is over
    function automatic bit wait_elapsed(logic [7:0] limit);
        bit waiting;
        waiting = seq_ticks < limit;
        seq_ticks = seq_ticks + 8'd1;
        if (waiting)
            return 1'b0;
        seq_ticks = 8'd0;
        return 1'b1;
    endfunction

    // Apply one request to the predicted state and return the result it produces
    function automatic mhps_pkg::t_result advance_sequencer(mhps_pkg::t_item it);
        mhps_pkg::t_result r;
        bit      more;
        r = '0;
        case (it.req_type)
            mhps_pkg::REQ_CMD: begin
                if ((it.cmd_option == settings.open_code
                     || it.cmd_option == settings.close_code)
                    && it.cmd_device == settings.device_code) begin
                    seq_mode = (it.cmd_option == settings.open_code) ? mhps_pkg::MODE_ON
                                                                      : mhps_pkg::MODE_OFF;
                    seq_retries = 3'd0;
                    r.accepted = 1'b1;
                end
            end
            mhps_pkg::REQ_RETRY: begin
                if (seq_mode == mhps_pkg::MODE_OFF)
                    seq_retries = 3'd0;
            end
            mhps_pkg::REQ_ARM: begin
                seq_armed = 1'b1;
                seq_on_done = 1'b0;
                seq_off_done = 1'b0;
                seq_exit_ok = 1'b0;
                seq_mode = mhps_pkg::MODE_NONE;
                seq_ticks = 8'd0;
                seq_retries = 3'd0;
            end
            default: begin
                if (settings.enable && seq_armed) begin
                    if (seq_mode == mhps_pkg::MODE_ON && !seq_on_done) begin
                        seq_off_done = 1'b0;
                        if (!it.sense_off) begin
                            seq_on_done = 1'b1;
                            seq_exit_ok = 1'b0;
                        end else if (wait_elapsed(settings.open_wait)) begin
                            r.supply_action = mhps_pkg::ACT_ON;
                            r.pulse_action = mhps_pkg::ACT_ON;
                        end
                    end else if (seq_mode == mhps_pkg::MODE_OFF && !seq_off_done) begin
                        seq_on_done = 1'b0;
                        if (it.recorder_idle)
                            seq_exit_ok = 1'b1;
                        if (it.sense_off) begin
                            seq_off_done = 1'b1;
                            r.supply_action = mhps_pkg::ACT_OFF;
                            seq_exit_ok = 1'b0;
                        end else if (wait_elapsed(settings.close_wait)) begin
                            if (seq_exit_ok) begin
                                r.pulse_action = mhps_pkg::ACT_OFF;
                            end else begin
                                more = seq_retries < settings.retry_limit;
                                seq_retries = seq_retries + 3'd1;
                                if (more) begin
                                    if (!it.peer_known)
                                        r.address_query = 1'b1;
                                    else
                                        r.status_query = 1'b1;
                                end else begin
                                    r.forced_shutdown = 1'b1;
                                    seq_exit_ok = 1'b1;
                                    seq_retries = 3'd0;
                                end
                            end
                        end
                    end
                end
            end
        endcase
        r.is_on = seq_on_done;
        r.is_off = seq_off_done;
        return r;
    endfunction

    function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic mhps_pkg::t_item random_item();
        mhps_pkg::t_item it;
        it = $bits(mhps_pkg::t_item)'($urandom);
        return it;
    endfunction

    // Check each taken result and drive the result-side stall
    always @(posedge i_clk) begin : result_check
        mhps_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with no request outstanding", $time);
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("accepted", 2'(want.accepted), 2'(o_accepted));
                check_field("supply_action", want.supply_action, o_supply_action);
                check_field("pulse_action", want.pulse_action, o_pulse_action);
                check_field("status_query", 2'(want.status_query), 2'(o_status_query));
                check_field("address_query", 2'(want.address_query), 2'(o_address_query));
                check_field("forced_shutdown", 2'(want.forced_shutdown),
                            2'(o_forced_shutdown));
                check_field("is_on", 2'(want.is_on), 2'(o_is_on));
                check_field("is_off", 2'(want.is_off), 2'(o_is_off));
            end
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= receiver_idle && ($urandom_range(0, 99) < 29);
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("media_host_power_sequencer verification failed");
            $finish;
        end
    end

    // Offer one request, hold it until taken, then record its expected result
    task automatic send_request(mhps_pkg::t_item it);
        while (sender_idle && $urandom_range(0, 99) < 29) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= it.req_type;
        i_cmd_device    <= it.cmd_device;
        i_cmd_option    <= it.cmd_option;
        i_sense_off     <= it.sense_off;
        i_recorder_idle <= it.recorder_idle;
        i_peer_known    <= it.peer_known;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(advance_sequencer(it));
    endtask

    task automatic send_fields(logic [1:0] req, logic [7:0] dev, logic [7:0] opt,
                               logic sense, logic rec, logic peer);
        send_request('{req_type: req, cmd_device: dev, cmd_option: opt,
                       sense_off: sense, recorder_idle: rec, peer_known: peer});
    endtask

    // Drop valid and wait until every outstanding result has been taken
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic write_register(logic [mhps_pkg::CFG_IDX_W-1:0] idx,
                                  logic [mhps_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Program every register once the block has gone idle
    task automatic apply_settings(mhps_pkg::t_cfg s, logic [15:0] port);
        wait_results_done();
        write_register(mhps_pkg::CFG_ENABLE, {15'd0, s.enable});
        write_register(mhps_pkg::CFG_POWER_PORT, port);
        write_register(mhps_pkg::CFG_OPEN_WAIT, {8'd0, s.open_wait});
        write_register(mhps_pkg::CFG_CLOSE_WAIT, {8'd0, s.close_wait});
        write_register(mhps_pkg::CFG_RETRY_LIMIT, {13'd0, s.retry_limit});
        write_register(mhps_pkg::CFG_DEVICE_CODE, {8'd0, s.device_code});
        write_register(mhps_pkg::CFG_OPEN_CODE, {8'd0, s.open_code});
        write_register(mhps_pkg::CFG_CLOSE_CODE, {8'd0, s.close_code});
        i_cfg_valid <= 1'b0;
        settings = s;
    endtask

    // Short waits most of the time so retries and forced shutdowns are reached
    task automatic randomize_settings();
        mhps_pkg::t_cfg s;
        s.enable      = ($urandom_range(0, 9) != 0);
        s.open_wait   = 8'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 4));
        s.close_wait  = 8'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 4));
        s.retry_limit = 3'($urandom_range(0, 7));
        s.device_code = 8'($urandom);
        s.open_code   = 8'($urandom);
        s.close_code  = ($urandom_range(0, 7) == 0) ? s.open_code : 8'($urandom);
        apply_settings(s, 16'($urandom));
    endtask

    // Arm, select a mode, then a run of ticks with a plausible sense level; some noise
    task automatic run_sequences(int item_budget, int off_share);
        int    sent;
        int    roll;
        bit    to_on;
        mhps_pkg::t_item it;
        sent = 0;
        while (sent < item_budget) begin
            if ($urandom_range(0, 5) == 0)
                randomize_settings();
            if ($urandom_range(0, 9) != 0) begin
                it = random_item();
                it.req_type = mhps_pkg::REQ_ARM;
                send_request(it);
                sent++;
            end
            to_on = $urandom_range(0, 99) >= off_share;
            it = random_item();
            it.req_type = mhps_pkg::REQ_CMD;
            it.cmd_device = settings.device_code;
            it.cmd_option = to_on ? settings.open_code : settings.close_code;
            send_request(it);
            sent++;
            repeat ($urandom_range(2, 40)) begin
                it = random_item();
                roll = $urandom_range(0, 99);
                if (roll >= 8) begin
                    if (!to_on && roll < 14) begin
                        it.req_type = mhps_pkg::REQ_RETRY;
                    end else begin
                        it.req_type = mhps_pkg::REQ_TICK;
                        if (to_on) begin
                            it.sense_off = ($urandom_range(0, 99) < 80);
                        end else begin
                            it.sense_off = ($urandom_range(0, 99) < 8);
                            it.recorder_idle = ($urandom_range(0, 99) < 15);
                        end
                    end
                end
                send_request(it);
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        // Defaults: commands before arming, rejects, a full on and off pass
        send_fields(mhps_pkg::REQ_TICK, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
        send_fields(mhps_pkg::REQ_CMD, 8'h00, mhps_pkg::OPEN_CODE_RST, 1'b0, 1'b0, 1'b0);
        send_fields(mhps_pkg::REQ_CMD, 8'hFF, mhps_pkg::OPEN_CODE_RST, 1'b1, 1'b1, 1'b1);
        send_fields(mhps_pkg::REQ_CMD, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0);
        send_fields(mhps_pkg::REQ_RETRY, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
        send_fields(mhps_pkg::REQ_ARM, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        send_fields(mhps_pkg::REQ_TICK, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
        send_fields(mhps_pkg::REQ_CMD, 8'h00, mhps_pkg::OPEN_CODE_RST, 1'b0, 1'b0, 1'b0);
        send_fields(mhps_pkg::REQ_TICK, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
        send_fields(mhps_pkg::REQ_TICK, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        send_fields(mhps_pkg::REQ_CMD, 8'h00, mhps_pkg::CLOSE_CODE_RST, 1'b0, 1'b0, 1'b0);
        send_fields(mhps_pkg::REQ_TICK, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        send_fields(mhps_pkg::REQ_RETRY, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        send_fields(mhps_pkg::REQ_TICK, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);

        // Disabled, with equal open and close codes: the command selects on mode
        apply_settings('{enable: 1'b0, open_wait: 8'd0, close_wait: 8'd0, retry_limit: 3'd0,
                         device_code: 8'hFF, open_code: 8'hFF, close_code: 8'hFF}, 16'h0000);
        send_fields(mhps_pkg::REQ_ARM, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        send_fields(mhps_pkg::REQ_CMD, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
        send_fields(mhps_pkg::REQ_TICK, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);

        // Re-enable with new codes; the selected mode holds, zero waits and retries
        apply_settings('{enable: 1'b1, open_wait: 8'd0, close_wait: 8'd0, retry_limit: 3'd0,
                         device_code: 8'hFF, open_code: 8'h00, close_code: 8'hFF}, 16'h0000);
        send_fields(mhps_pkg::REQ_TICK, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
        send_fields(mhps_pkg::REQ_TICK, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        send_fields(mhps_pkg::REQ_CMD, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0);
        send_fields(mhps_pkg::REQ_TICK, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
        send_fields(mhps_pkg::REQ_TICK, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        send_fields(mhps_pkg::REQ_TICK, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);

        // Largest waits and retry limit
        apply_settings('{enable: 1'b1, open_wait: 8'd255, close_wait: 8'd255,
                         retry_limit: 3'd7, device_code: 8'hA5, open_code: 8'h5A,
                         close_code: 8'hA5}, 16'hFFFF);
        send_fields(mhps_pkg::REQ_ARM, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        send_fields(mhps_pkg::REQ_CMD, 8'hA5, 8'h5A, 1'b0, 1'b0, 1'b0);
        send_fields(mhps_pkg::REQ_TICK, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_power_on_sequences();
        run_sequences(200, 15);
    endtask

    task automatic test_power_off_sequences();
        run_sequences(350, 85);
    endtask

    // Hold off the result side so the block fills and stalls requests
    task automatic test_backpressure();
        sender_idle = 1'b0;
        receiver_idle = 1'b0;
        hold_left = 80;
        run_sequences(35, 50);
        wait_results_done();
        hold_left = 40;
        run_sequences(35, 50);
        wait_results_done();
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        sender_idle = 1'b0;
        receiver_idle = 1'b0;
        run_sequences(200, 50);
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
    endtask

    task automatic test_random_noise();
        mhps_pkg::t_item it;
        for (int n = 0; n < 200; n++) begin
            if (n % 40 == 0)
                randomize_settings();
            it = random_item();
            if ($urandom_range(0, 3) == 0 && it.req_type == mhps_pkg::REQ_CMD) begin
                it.cmd_device = settings.device_code;
                it.cmd_option = $urandom_range(0, 1) ? settings.open_code
                                                     : settings.close_code;
            end
            send_request(it);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_power_on_sequences();
        test_power_off_sequences();
        test_backpressure();
        test_steady_stream();
        test_random_noise();
        wait_results_done();
        repeat (RETIRE_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("media_host_power_sequencer verification clean");
        else
            $display("media_host_power_sequencer verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/mhps_pkg.sv
src/mhps_cfg.sv
src/mhps_core.sv
src/media_host_power_sequencer.sv
tb/media_host_power_sequencer_test.sv
